[design/delete_and_find_next_present_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the present-set successor block
// Shared property shapes, clocked and gated by reset.
// ----------------------------------------------------------------------------
`ifndef DELETE_AND_FIND_NEXT_PRESENT_DEFINES_SVH
`define DELETE_AND_FIND_NEXT_PRESENT_DEFINES_SVH

// Same-cycle implication.
`define DFNP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfnp: same-cycle check failed");

// Next-cycle implication.
`define DFNP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfnp: next-cycle check failed");

`endif

[design/dfnp_pkg.sv]
// ----------------------------------------------------------------------------
// dfnp_pkg
// Shared widths, defaults, command codes and word types of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package dfnp_pkg;

   localparam int VALUE_W           = 11;
   localparam int SET_SIZE_DEFAULT  = 1024;
   localparam int WORD_BITS_DEFAULT = 64;

   localparam logic [VALUE_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic CMD_REMOVE = 1'b0;
   localparam logic CMD_FIND   = 1'b1;

   typedef struct packed {
      logic               cmd;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] next_value;
   } rsp_type;

endpackage

`default_nettype wire

[design/dfnp_ram.sv]
// ----------------------------------------------------------------------------
// dfnp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dfnp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/delete_and_find_next_present.sv]
// ----------------------------------------------------------------------------
// delete_and_find_next_present
// Set of values 1..limit with remove and find-next-present commands.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_data) takes one command word:
//   cmd = remove deletes value, cmd = find asks for the smallest present
//   value not below value. Only finds produce a word on the rsp channel
//   (rsp_valid / rsp_stall / rsp_data): found plus next_value, 0 if none.
//   csr channel writes upper_limit; csr_ready is always high. Write it only
//   while no command is in flight.
// Steps:
//   A command runs capture and quotient, then word split plus RAM read,
//   then read-modify-write or bit search on the RAM word. A value outside
//   1..limit (find bound 0 counts as 1) ends after the split. A find whose
//   bound word holds nothing at or above the bound reads the next nonempty
//   word from the summary. A find result goes to the output register at
//   its last step, which waits while that register is full and stalled.
// Reset (synchronous): every value present, limit 1024. Presence of words
//   never written comes from per-word written flags, so no clearing pass.
// A stalled result holds in the output register; the next command is still
//   accepted and waits only if it needs the output register while it is full.
// ----------------------------------------------------------------------------
`default_nettype none
`include "delete_and_find_next_present_defines.svh"

module delete_and_find_next_present
   import dfnp_pkg::*;
#(
   parameter int SET_SIZE  = SET_SIZE_DEFAULT,
   parameter int WORD_BITS = WORD_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [VALUE_W-1:0] csr_data
);

   localparam int VALUE_MAX   = (1 << VALUE_W) - 1;
   localparam int LIM_CAP     = (SET_SIZE > VALUE_MAX) ? VALUE_MAX : SET_SIZE;
   localparam int USED_WORDS  = (LIM_CAP + WORD_BITS - 1) / WORD_BITS;
   localparam int WAW         = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
   localparam int BW          = $clog2(WORD_BITS);
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;

   localparam logic [VALUE_W-1:0] LIM_CAP_V   = VALUE_W'(LIM_CAP);
   localparam logic [VALUE_W-1:0] WORD_BITS_V = VALUE_W'(WORD_BITS);
   localparam logic [VALUE_W-1:0] ONE_V       = VALUE_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIX,
      ST_WORD1,
      ST_WORD2
   } state_type;

   state_type              state_ff;
   logic [VALUE_W-1:0]     limit_ff;
   logic                   cmd_ff;
   logic [VALUE_W-1:0]     value_ff;
   logic [WAW-1:0]         quot_ff;
   logic [WAW-1:0]         word_ff;
   logic [BW-1:0]          bit_ff;
   logic [VALUE_W-1:0]     base_ff;
   logic [USED_WORDS-1:0]  summary_ff;
   logic [USED_WORDS-1:0]  written_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   logic [VALUE_W-1:0]     lim;
   logic [VALUE_W-1:0]     acc_bound;
   logic [VALUE_W-1:0]     acc_idx;
   logic [31:0]            acc_prod;
   logic [WAW-1:0]         quot_in;

   logic [VALUE_W-1:0]     fix_bound;
   logic [VALUE_W-1:0]     fix_idx;
   logic [VALUE_W-1:0]     fix_qbase;
   logic [VALUE_W-1:0]     fix_rem;
   logic [VALUE_W-1:0]     fix_rem_low;
   logic                   fix_over;
   logic                   in_range;
   logic [WAW-1:0]         fix_word;
   logic [BW-1:0]          fix_bit;
   logic [VALUE_W-1:0]     fix_base;

   logic [WORD_BITS-1:0]   ram_rdata;
   logic [WORD_BITS-1:0]   word_data;
   logic [WORD_BITS-1:0]   masked;
   logic [WORD_BITS-1:0]   cleared;
   logic [BW-1:0]          low_bit;
   logic [VALUE_W:0]       cand;
   logic                   hit_ok;
   logic                   nxt_hit;
   logic [WAW-1:0]         nxt_word;
   logic                   go_second;

   logic                   out_free;
   logic                   emit;
   rsp_type                emit_data;
   logic                   ram_wr_en;
   logic                   ram_rd_en;
   logic [WAW-1:0]         ram_rd_addr;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign lim = (limit_ff > LIM_CAP_V) ? LIM_CAP_V : limit_ff;

   // Word index of the bound by reciprocal multiply; may come out one low.
   assign acc_bound = (req_data.value == '0) ? ONE_V : req_data.value;
   assign acc_idx   = acc_bound - ONE_V;
   assign acc_prod  = 32'(acc_idx) * 32'(RECIP);
   assign quot_in   = acc_prod[RECIP_SHIFT +: WAW];

   // Correct the quotient by one compare and subtract.
   assign fix_bound   = (value_ff == '0) ? ONE_V : value_ff;
   assign fix_idx     = fix_bound - ONE_V;
   assign fix_qbase   = VALUE_W'(quot_ff) * WORD_BITS_V;
   assign fix_rem     = fix_idx - fix_qbase;
   assign fix_rem_low = fix_rem - WORD_BITS_V;
   assign fix_over    = (fix_rem >= WORD_BITS_V);
   assign fix_word    = fix_over ? quot_ff + WAW'(1) : quot_ff;
   assign fix_bit     = fix_over ? fix_rem_low[BW-1:0] : fix_rem[BW-1:0];
   assign fix_base    = fix_over ? fix_qbase + WORD_BITS_V : fix_qbase;
   assign in_range    = (fix_bound <= lim) &&
                        !((cmd_ff == CMD_REMOVE) && (value_ff == '0));

   // Words never written are taken as all ones, the reset state of the set.
   assign word_data = written_ff[word_ff] ? ram_rdata : {WORD_BITS{1'b1}};
   assign masked    = word_data & ({WORD_BITS{1'b1}} << bit_ff);
   assign cleared   = word_data & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff);

   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (masked[i]) begin
            low_bit = BW'(i);
         end
      end
   end

   // First nonempty word above the current one.
   always_comb begin
      nxt_hit  = 1'b0;
      nxt_word = '0;
      for (int i = USED_WORDS - 1; i >= 0; i--) begin
         if (summary_ff[i] && (i > int'(word_ff))) begin
            nxt_hit  = 1'b1;
            nxt_word = WAW'(i);
         end
      end
   end

   assign cand   = {1'b0, base_ff} + (VALUE_W+1)'(low_bit) + (VALUE_W+1)'(1);
   assign hit_ok = (masked != '0) && (cand <= {1'b0, lim});

   assign go_second = (state_ff == ST_WORD1) && (cmd_ff == CMD_FIND) &&
                      (masked == '0) && nxt_hit;

   always_comb begin
      emit = 1'b0;
      case (state_ff)
         ST_FIX:   emit = (cmd_ff == CMD_FIND) && !in_range;
         ST_WORD1: emit = (cmd_ff == CMD_FIND) && !go_second;
         ST_WORD2: emit = 1'b1;
         default:  emit = 1'b0;
      endcase
      emit = emit && out_free;
   end

   assign emit_data.found      = (state_ff != ST_FIX) && hit_ok;
   assign emit_data.next_value = emit_data.found ? cand[VALUE_W-1:0] : '0;

   assign ram_wr_en   = (state_ff == ST_WORD1) && (cmd_ff == CMD_REMOVE);
   assign ram_rd_en   = ((state_ff == ST_FIX) && in_range) || go_second;
   assign ram_rd_addr = (state_ff == ST_FIX) ? fix_word : nxt_word;

   dfnp_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (USED_WORDS),
      .AW    (WAW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (word_ff),
      .wr_data (cleared),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         summary_ff   <= '1;
         written_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= emit_data;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall) begin
                  cmd_ff   <= req_data.cmd;
                  value_ff <= req_data.value;
                  quot_ff  <= quot_in;
                  state_ff <= ST_FIX;
               end
            end
            ST_FIX: begin
               word_ff <= fix_word;
               bit_ff  <= fix_bit;
               base_ff <= fix_base;
               if (in_range) begin
                  state_ff <= ST_WORD1;
               end else if (cmd_ff == CMD_REMOVE || out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WORD1: begin
               if (cmd_ff == CMD_REMOVE) begin
                  // write back the word with the bit dropped
                  written_ff[word_ff] <= 1'b1;
                  summary_ff[word_ff] <= (cleared != '0);
                  state_ff            <= ST_IDLE;
               end else if (go_second) begin
                  word_ff  <= nxt_word;
                  bit_ff   <= '0;
                  base_ff  <= VALUE_W'(nxt_word) * WORD_BITS_V;
                  state_ff <= ST_WORD2;
               end else if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WORD2: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `DFNP_ASSERT_SAME(a_rsp_only_for_find, clock, reset, $rose(rsp_valid_ff), cmd_ff == CMD_FIND)
   `DFNP_ASSERT_SAME(a_not_found_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.found, rsp_data_ff.next_value == '0)
   `DFNP_ASSERT_NEXT(a_remove_done, clock, reset, state_ff == ST_WORD1 && cmd_ff == CMD_REMOVE, state_ff == ST_IDLE)

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: delete_and_find_next_present
// Drives remove and find words through the block under stalls and gaps.
// Each find is checked against a typed answer of the directed plan or a
// bitmap model of the present set that follows the upper_limit writes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import dfnp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_SIZE     = SET_SIZE_DEFAULT;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int SETTLE_TAIL  = 8;
   localparam int PHASE_WORDS  = 200;
   localparam int RANDOM_WORDS = 1600;

   typedef enum logic [1:0] {
      ROW_REMOVE,
      ROW_FIND,
      ROW_LIMIT
   } row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [VALUE_W-1:0] arg;
      bit                 typed;
      logic               found;
      logic [VALUE_W-1:0] next_value;
   } directed_row_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [VALUE_W-1:0] csr_data  = '0;

   // model of the set: bit v-1 holds value v
   logic [SET_SIZE-1:0] present_bits = '1;
   logic [VALUE_W-1:0]  limit_reg    = LIMIT_RESET;

   rsp_type expected_answers[$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   int      burst_left     = 1;
   bit      gapless        = 1'b0;
   bit      rsp_held_off   = 1'b0;

   directed_row_type plan [28] = '{
      '{ROW_FIND,   11'd0,    1'b1, 1'b1, 11'd1},
      '{ROW_FIND,   11'd1024, 1'b1, 1'b1, 11'd1024},
      '{ROW_FIND,   11'd1025, 1'b1, 1'b0, 11'd0},
      '{ROW_FIND,   11'd2047, 1'b1, 1'b0, 11'd0},
      '{ROW_REMOVE, 11'd0,    1'b0, 1'b0, 11'd0},
      '{ROW_REMOVE, 11'd2047, 1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd1,    1'b1, 1'b1, 11'd1},
      '{ROW_REMOVE, 11'd1,    1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd0,    1'b1, 1'b1, 11'd2},
      '{ROW_REMOVE, 11'd1024, 1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd1024, 1'b1, 1'b0, 11'd0},
      '{ROW_REMOVE, 11'd64,   1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd64,   1'b0, 1'b0, 11'd0},
      '{ROW_REMOVE, 11'd65,   1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd63,   1'b0, 1'b0, 11'd0},
      '{ROW_LIMIT,  11'd0,    1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd1,    1'b1, 1'b0, 11'd0},
      '{ROW_REMOVE, 11'd5,    1'b0, 1'b0, 11'd0},
      '{ROW_LIMIT,  11'd2047, 1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd1020, 1'b1, 1'b1, 11'd1020},
      '{ROW_FIND,   11'd1024, 1'b1, 1'b0, 11'd0},
      '{ROW_LIMIT,  11'd10,   1'b0, 1'b0, 11'd0},
      '{ROW_REMOVE, 11'd11,   1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd10,   1'b1, 1'b1, 11'd10},
      '{ROW_FIND,   11'd11,   1'b1, 1'b0, 11'd0},
      '{ROW_LIMIT,  11'd1024, 1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd5,    1'b0, 1'b0, 11'd0},
      '{ROW_FIND,   11'd11,   1'b0, 1'b0, 11'd0}
   };

   delete_and_find_next_present DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int unsigned visible_limit();
      return (limit_reg > SET_SIZE) ? SET_SIZE : limit_reg;
   endfunction

   function automatic rsp_type next_present_answer(logic [VALUE_W-1:0] bound);
      rsp_type     ans;
      int unsigned lim;
      int unsigned k;
      ans = '0;
      lim = visible_limit();
      k = (bound == 0) ? 1 : bound;
      for (; k <= lim; k++) begin
         if (present_bits[k-1]) begin
            ans.found      = 1'b1;
            ans.next_value = VALUE_W'(k);
            break;
         end
      end
      return ans;
   endfunction

   task automatic strike_value(logic [VALUE_W-1:0] value);
      if (value != 0 && value <= visible_limit())
         present_bits[value-1] = 1'b0;
   endtask

   // drop valid and hold until every find has answered and the pipe is empty
   task automatic settle_answers();
      req_valid <= 1'b0;
      while (expected_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_TAIL) @(posedge clock);
   endtask

   task automatic write_upper_limit(logic [VALUE_W-1:0] value);
      settle_answers();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_reg = value;
   endtask

   task automatic issue_word(logic cmd, logic [VALUE_W-1:0] value, bit typed,
                             rsp_type typed_ans);
      req_type word;
      int      gap;
      word.cmd   = cmd;
      word.value = value;
      req_valid <= 1'b1;
      req_data  <= word;
      do @(posedge clock); while (req_stall);
      if (cmd == CMD_FIND)
         expected_answers = {expected_answers,
                             typed ? typed_ans : next_present_answer(value)};
      else
         strike_value(value);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gapless || rsp_held_off) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // receiver: changing stall patterns, with a long hold-off now and then
   initial begin : rsp_pacer
      int mode = 0;
      int left = 0;
      int hold = 0;
      int tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (tick % 1800 == 900)
            hold = $urandom_range(150, 250);
         if (hold > 0) begin
            rsp_held_off = 1'b1;
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            rsp_held_off = 1'b0;
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(40, 300);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((tick % 7) < 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin : answer_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: found=%0d next_value=%0d",
                        rsp_data.found, rsp_data.next_value);
         end else begin
            want = expected_answers.pop_front();
            if (rsp_data.found !== want.found || rsp_data.next_value !== want.next_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected found=%0d next_value=%0d, got found=%0d next_value=%0d",
                           want.found, want.next_value, rsp_data.found, rsp_data.next_value);
            end
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          words;
      int          pick;
      int          base;
      int          len;
      int          k;
      int unsigned lim;
      rsp_type     typed_ans;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         typed_ans.found      = plan[i].found;
         typed_ans.next_value = plan[i].next_value;
         case (plan[i].kind)
            ROW_LIMIT:  write_upper_limit(plan[i].arg);
            ROW_REMOVE: issue_word(CMD_REMOVE, plan[i].arg, 1'b0, '0);
            default:    issue_word(CMD_FIND, plan[i].arg, plan[i].typed, typed_ans);
         endcase
      end

      words = 0;
      for (phase = 0; words < RANDOM_WORDS; phase++) begin
         case (phase % 8)
            0: write_upper_limit(11'd1024);
            1: write_upper_limit(11'd2047);
            2: write_upper_limit(11'd700);
            3: write_upper_limit(11'd64);
            4: write_upper_limit(11'd1);
            5: write_upper_limit(11'd1500);
            6: write_upper_limit(VALUE_W'($urandom_range(1, 1024)));
            default: write_upper_limit(11'd1024);
         endcase
         gapless = (phase % 3 == 2);
         lim = visible_limit();
         for (int n = 0; n < PHASE_WORDS; ) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               if ($urandom_range(0, 9) < 7)
                  issue_word(CMD_FIND, VALUE_W'($urandom_range(0, lim + 1)), 1'b0, '0);
               else
                  issue_word(CMD_FIND, VALUE_W'($urandom_range(0, 2047)), 1'b0, '0);
               n++;
            end else if (pick < 80) begin
               if ($urandom_range(0, 9) < 8)
                  issue_word(CMD_REMOVE, VALUE_W'($urandom_range(0, 1100)), 1'b0, '0);
               else
                  issue_word(CMD_REMOVE, VALUE_W'($urandom_range(0, 2047)), 1'b0, '0);
               n++;
            end else if (pick < 90 || (pick == 90 && phase >= 4)) begin
               // short run of removes, then find from its start
               base = $urandom_range(1, 1024);
               len  = $urandom_range(2, 6);
               for (k = base; k < base + len && k <= 2047; k++) begin
                  issue_word(CMD_REMOVE, VALUE_W'(k), 1'b0, '0);
                  n++;
               end
               issue_word(CMD_FIND, VALUE_W'(base), 1'b0, '0);
               n++;
            end else if (pick == 90) begin
               // empty whole words so the search has to skip via the summary
               base = $urandom_range(0, 15) * 64 + 1;
               len  = $urandom_range(64, 130);
               for (k = base; k < base + len && k <= 2047; k++) begin
                  issue_word(CMD_REMOVE, VALUE_W'(k), 1'b0, '0);
                  n++;
               end
               issue_word(CMD_FIND, VALUE_W'(base), 1'b0, '0);
               issue_word(CMD_FIND, VALUE_W'(base + len / 2), 1'b0, '0);
               n += 2;
            end else begin
               case ($urandom_range(0, 4))
                  0: issue_word(CMD_FIND, 11'd0, 1'b0, '0);
                  1: issue_word(CMD_FIND, VALUE_W'(lim), 1'b0, '0);
                  2: issue_word(CMD_FIND, VALUE_W'(lim + 1), 1'b0, '0);
                  3: issue_word(CMD_FIND, 11'd2047, 1'b0, '0);
                  default: issue_word(CMD_FIND, 11'd1024, 1'b0, '0);
               endcase
               n++;
            end
         end
         words += PHASE_WORDS;
      end

      settle_answers();
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/dfnp_pkg.sv
design/dfnp_ram.sv
design/delete_and_find_next_present.sv
tb/tb.sv
